/* hw/rtl/c_source_tokenizer_top_defines.svh */
// Assertion macros shared by the tokenizer RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef C_SOURCE_TOKENIZER_TOP_DEFINES_SVH
`define C_SOURCE_TOKENIZER_TOP_DEFINES_SVH

// Property checked at every rising edge, switched off while in reset.
`define CTOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define CTOK_ASSERT_IMP(lbl, ante, cons, msg) \
  `CTOK_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define CTOK_ASSERT_NXT(lbl, ante, cons, msg) \
  `CTOK_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* hw/rtl/ctok_pkg.sv */
// Types, character codes and helper functions for the C source tokenizer.
// Used by c_source_tokenizer_top; depends on nothing else.
package ctok_pkg;

  localparam int ByteW    = 8;
  localparam int KindW    = 3;
  localparam int LineOutW = 16;
  localparam int MaxRes   = 4;

  localparam logic [ByteW-1:0] CH_EQ     = 8'h3D;
  localparam logic [ByteW-1:0] CH_PLUS   = 8'h2B;
  localparam logic [ByteW-1:0] CH_MINUS  = 8'h2D;
  localparam logic [ByteW-1:0] CH_AMP    = 8'h26;
  localparam logic [ByteW-1:0] CH_BAR    = 8'h7C;
  localparam logic [ByteW-1:0] CH_GT     = 8'h3E;
  localparam logic [ByteW-1:0] CH_DOT    = 8'h2E;
  localparam logic [ByteW-1:0] CH_USCORE = 8'h5F;
  localparam logic [ByteW-1:0] CH_DQUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_SQUOTE = 8'h27;
  localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ByteW-1:0] CH_NL     = 8'h0A;
  localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
  localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
  localparam logic [ByteW-1:0] CH_SLASH  = 8'h2F;
  localparam logic [ByteW-1:0] CH_STAR   = 8'h2A;
  localparam logic [ByteW-1:0] CH_NUL    = 8'h00;

  typedef enum logic [KindW-1:0] {
    KIND_NUMBER = 3'd0,
    KIND_IDENT  = 3'd1,
    KIND_STRING = 3'd2,
    KIND_CHAR   = 3'd3,
    KIND_SYMBOL = 3'd4,
    KIND_END    = 3'd5
  } tok_kind_e;

  typedef enum logic [11:0] {
    MODE_NORMAL     = 12'b0000_0000_0001,
    MODE_NUM        = 12'b0000_0000_0010,
    MODE_IDENT      = 12'b0000_0000_0100,
    MODE_STR        = 12'b0000_0000_1000,
    MODE_STR_ESC    = 12'b0000_0001_0000,
    MODE_CHAR_OPEN  = 12'b0000_0010_0000,
    MODE_CHAR_CLOSE = 12'b0000_0100_0000,
    MODE_LINE_CMT   = 12'b0000_1000_0000,
    MODE_BLOCK      = 12'b0001_0000_0000,
    MODE_BLOCK_STAR = 12'b0010_0000_0000,
    MODE_SKIP       = 12'b0100_0000_0000,
    MODE_SYM        = 12'b1000_0000_0000
  } scan_mode_e;

  // One token byte requested by the scan; late marks bytes emitted at end of source.
  typedef struct packed {
    tok_kind_e        kind;
    logic [ByteW-1:0] ch;
    logic             fin;
    logic             late;
  } req_t;

  typedef struct packed {
    req_t [MaxRes-1:0] item;
    logic [2:0]        cnt;
  } req_list_t;

  typedef struct packed {
    logic [ByteW-1:0]    ch;
    tok_kind_e           kind;
    logic                start;
    logic                fin;
    logic [LineOutW-1:0] line;
    logic                blank;
  } tok_t;

  function automatic logic is_digit(logic [ByteW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [ByteW-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Two-character operators other than the dot sequence.
  function automatic logic op_pairs(logic [ByteW-1:0] a, logic [ByteW-1:0] c);
    return (c == CH_EQ) || ((a == CH_PLUS) && (c == CH_PLUS)) ||
           ((a == CH_MINUS) && (c == CH_MINUS)) || ((a == CH_AMP) && (c == CH_AMP)) ||
           ((a == CH_BAR) && (c == CH_BAR)) || ((a == CH_MINUS) && (c == CH_GT));
  endfunction

  function automatic req_list_t push_req(req_list_t l, tok_kind_e k, logic [ByteW-1:0] c,
                                         logic fin, logic late);
    req_list_t r;
    r = l;
    if (r.cnt < 3'(MaxRes)) begin
      r.item[r.cnt[1:0]] = '{kind: k, ch: c, fin: fin, late: late};
      r.cnt = r.cnt + 3'd1;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/c_source_tokenizer_top.sv */
// C source tokenizer: byte scanner, result buffer and output register.
// Depends on ctok_pkg and c_source_tokenizer_top_defines.svh.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, source_byte_i,   | into block
//           | end_of_source_i                          |
//   out     | out_valid_o, out_ready_i, token_*_o,     | out of block
//           | line_number_o, blank_before_o, run_last_o|
//
// A byte is scanned in the cycle it is accepted and its results (up to four)
// land in a result buffer; they leave through the output register one per cycle
// unless the output stalls. A byte with at most one result does not hold the
// input, so the block then runs at one byte per cycle; more results hold the input
// while the buffer drains. Reset returns the scanner to normal scanning at line
// one with no clearing pass. A stalled output holds one result and lets one more byte in.

`include "c_source_tokenizer_top_defines.svh"

module c_source_tokenizer_top #(
  parameter int LINE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ctok_pkg::ByteW-1:0]     source_byte_i,
  input  logic                           end_of_source_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ctok_pkg::ByteW-1:0]     token_byte_o,
  output logic [ctok_pkg::KindW-1:0]     token_kind_o,
  output logic                           token_start_o,
  output logic                           token_finish_o,
  output logic [ctok_pkg::LineOutW-1:0]  line_number_o,
  output logic                           blank_before_o,
  output logic                           run_last_o
);
  import ctok_pkg::*;

  // Scanner state.
  scan_mode_e           mode_q;
  logic [ByteW-1:0]     held_q;
  logic [1:0]           hc_q;
  logic                 open_q;
  logic [LINE_BITS-1:0] line_q;
  logic                 blank_q;

  // Result buffer and output register.
  tok_t [MaxRes-1:0]    pend_q;
  logic [2:0]           rem_q;
  logic [1:0]           rd_q;
  tok_t                 out_q;
  logic                 out_valid_q;
  logic                 out_last_q;

  // Combinational scan results.
  scan_mode_e           mode_d;
  logic [ByteW-1:0]     held_d;
  logic [1:0]           hc_d;
  logic                 open_d;
  logic [LINE_BITS-1:0] line_d;
  logic                 blank_d;
  logic                 bump;
  logic                 blank_set;
  logic                 go_normal;
  logic                 blank_v;
  logic                 open_v;
  req_list_t            lst;
  req_t                 req_r;
  tok_t [MaxRes-1:0]    res_d;

  logic                 move;
  logic                 in_acc;

  function automatic logic [LineOutW-1:0] line_sat(logic [LINE_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'h0000_FFFF) begin
      return 16'hFFFF;
    end
    return w[LineOutW-1:0];
  endfunction

  always_comb begin : scan_step
    mode_d    = mode_q;
    held_d    = held_q;
    hc_d      = hc_q;
    bump      = 1'b0;
    blank_set = 1'b0;
    go_normal = 1'b0;
    lst       = '0;

    case (mode_q)
      MODE_NUM: begin
        if (is_digit(source_byte_i) || (source_byte_i == CH_DOT)) begin
          lst    = push_req(lst, KIND_NUMBER, held_q, 1'b0, 1'b0);
          held_d = source_byte_i;
        end else begin
          lst       = push_req(lst, KIND_NUMBER, held_q, 1'b1, 1'b0);
          go_normal = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_alpha(source_byte_i) || is_digit(source_byte_i) ||
            (source_byte_i == CH_USCORE)) begin
          lst    = push_req(lst, KIND_IDENT, held_q, 1'b0, 1'b0);
          held_d = source_byte_i;
        end else begin
          lst       = push_req(lst, KIND_IDENT, held_q, 1'b1, 1'b0);
          go_normal = 1'b1;
        end
      end
      MODE_STR: begin
        if (source_byte_i == CH_DQUOTE) begin
          lst    = push_req(lst, KIND_STRING, (hc_q != 2'd0) ? held_q : CH_NUL, 1'b1, 1'b0);
          hc_d   = 2'd0;
          mode_d = MODE_NORMAL;
        end else begin
          if (hc_q != 2'd0) begin
            lst = push_req(lst, KIND_STRING, held_q, 1'b0, 1'b0);
          end
          held_d = source_byte_i;
          hc_d   = 2'd1;
          if (source_byte_i == CH_BSLASH) begin
            mode_d = MODE_STR_ESC;
          end
        end
      end
      MODE_STR_ESC: begin
        lst    = push_req(lst, KIND_STRING, held_q, 1'b0, 1'b0);
        held_d = source_byte_i;
        hc_d   = 2'd1;
        mode_d = MODE_STR;
      end
      MODE_CHAR_OPEN: begin
        if (source_byte_i == CH_BSLASH) begin
          mode_d = MODE_SKIP;
        end else begin
          lst    = push_req(lst, KIND_CHAR, source_byte_i, 1'b1, 1'b0);
          bump   = (source_byte_i == CH_NL);
          mode_d = MODE_CHAR_CLOSE;
        end
      end
      MODE_CHAR_CLOSE: begin
        bump   = (source_byte_i == CH_NL);
        mode_d = MODE_NORMAL;
      end
      MODE_LINE_CMT, MODE_SKIP: begin
        if (source_byte_i == CH_NL) begin
          bump   = 1'b1;
          mode_d = MODE_NORMAL;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        bump = (source_byte_i == CH_NL);
        if ((mode_q == MODE_BLOCK_STAR) && (source_byte_i == CH_SLASH)) begin
          mode_d = MODE_NORMAL;
        end else if (source_byte_i == CH_STAR) begin
          mode_d = MODE_BLOCK_STAR;
        end else begin
          mode_d = MODE_BLOCK;
        end
      end
      MODE_SYM: begin
        if (hc_q == 2'd2) begin
          lst = push_req(lst, KIND_SYMBOL, CH_DOT, 1'b0, 1'b0);
          if (source_byte_i == CH_DOT) begin
            lst    = push_req(lst, KIND_SYMBOL, CH_DOT, 1'b0, 1'b0);
            lst    = push_req(lst, KIND_SYMBOL, CH_DOT, 1'b1, 1'b0);
            hc_d   = 2'd0;
            mode_d = MODE_NORMAL;
          end else begin
            lst       = push_req(lst, KIND_SYMBOL, CH_DOT, 1'b1, 1'b0);
            go_normal = 1'b1;
          end
        end else if (hc_q == 2'd1) begin
          if ((held_q == CH_SLASH) && (source_byte_i == CH_SLASH)) begin
            hc_d   = 2'd0;
            mode_d = MODE_LINE_CMT;
          end else if ((held_q == CH_SLASH) && (source_byte_i == CH_STAR)) begin
            hc_d   = 2'd0;
            mode_d = MODE_BLOCK;
          end else if ((held_q == CH_DOT) && (source_byte_i == CH_DOT)) begin
            hc_d = 2'd2;
          end else if (op_pairs(held_q, source_byte_i)) begin
            lst    = push_req(lst, KIND_SYMBOL, held_q, 1'b0, 1'b0);
            lst    = push_req(lst, KIND_SYMBOL, source_byte_i, 1'b1, 1'b0);
            hc_d   = 2'd0;
            mode_d = MODE_NORMAL;
          end else begin
            lst       = push_req(lst, KIND_SYMBOL, held_q, 1'b1, 1'b0);
            go_normal = 1'b1;
          end
        end else begin
          go_normal = 1'b1;
        end
      end
      default: begin
        go_normal = 1'b1;
      end
    endcase

    // Start of a new token or a skipped byte, from normal scanning.
    if (go_normal) begin
      hc_d = 2'd0;
      if (is_digit(source_byte_i)) begin
        mode_d = MODE_NUM;
        held_d = source_byte_i;
        hc_d   = 2'd1;
      end else if (is_alpha(source_byte_i) || (source_byte_i == CH_USCORE)) begin
        mode_d = MODE_IDENT;
        held_d = source_byte_i;
        hc_d   = 2'd1;
      end else if ((source_byte_i == CH_SPACE) || (source_byte_i == CH_TAB)) begin
        mode_d    = MODE_NORMAL;
        blank_set = 1'b1;
      end else if (source_byte_i == CH_BSLASH) begin
        mode_d = MODE_SKIP;
      end else if (source_byte_i == CH_DQUOTE) begin
        mode_d = MODE_STR;
      end else if (source_byte_i == CH_SQUOTE) begin
        mode_d = MODE_CHAR_OPEN;
      end else if (source_byte_i == CH_NL) begin
        mode_d = MODE_NORMAL;
        bump   = 1'b1;
      end else begin
        mode_d = MODE_SYM;
        held_d = source_byte_i;
        hc_d   = 2'd1;
      end
    end

    line_d = (bump && !(&line_q)) ? line_q + 1'b1 : line_q;

    // End of source closes any open token, then gives the end token.
    if (end_of_source_i) begin
      case (mode_d)
        MODE_NUM: begin
          if (hc_d != 2'd0) begin
            lst = push_req(lst, KIND_NUMBER, held_d, 1'b1, 1'b1);
          end
        end
        MODE_IDENT: begin
          if (hc_d != 2'd0) begin
            lst = push_req(lst, KIND_IDENT, held_d, 1'b1, 1'b1);
          end
        end
        MODE_STR, MODE_STR_ESC: begin
          lst = push_req(lst, KIND_STRING, (hc_d != 2'd0) ? held_d : CH_NUL, 1'b1, 1'b1);
        end
        MODE_SYM: begin
          if (hc_d == 2'd2) begin
            lst = push_req(lst, KIND_SYMBOL, CH_DOT, 1'b0, 1'b1);
            lst = push_req(lst, KIND_SYMBOL, CH_DOT, 1'b1, 1'b1);
          end else if (hc_d == 2'd1) begin
            lst = push_req(lst, KIND_SYMBOL, held_d, 1'b1, 1'b1);
          end
        end
        default: begin
        end
      endcase
      lst = push_req(lst, KIND_END, CH_NUL, 1'b1, 1'b1);
    end

    // Stamp start, line and blank marks in emission order.
    open_v  = open_q;
    blank_v = blank_q;
    req_r   = '0;
    for (int i = 0; i < MaxRes; i++) begin
      res_d[i] = '0;
      if (3'(i) < lst.cnt) begin
        req_r = lst.item[i];
        if (req_r.late) begin
          blank_v = blank_v | blank_set;
        end
        res_d[i].ch    = req_r.ch;
        res_d[i].kind  = req_r.kind;
        res_d[i].start = (req_r.kind == KIND_END) || !open_v;
        res_d[i].fin   = req_r.fin;
        res_d[i].line  = req_r.late ? line_sat(line_d) : line_sat(line_q);
        res_d[i].blank = blank_v;
        open_v = !req_r.fin;
        if (req_r.fin) begin
          blank_v = 1'b0;
        end
      end
    end
    open_d  = open_v;
    blank_d = blank_v | blank_set;
  end

  assign move       = (rem_q != 3'd0) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (rem_q == 3'd0) || ((rem_q == 3'd1) && move);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NORMAL;
      hc_q        <= 2'd0;
      open_q      <= 1'b0;
      line_q      <= LINE_BITS'(1);
      blank_q     <= 1'b0;
      rem_q       <= 3'd0;
      rd_q        <= 2'd0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        if (end_of_source_i) begin
          mode_q  <= MODE_NORMAL;
          hc_q    <= 2'd0;
          open_q  <= 1'b0;
          line_q  <= LINE_BITS'(1);
          blank_q <= 1'b0;
        end else begin
          mode_q  <= mode_d;
          hc_q    <= hc_d;
          open_q  <= open_d;
          line_q  <= line_d;
          blank_q <= blank_d;
        end
        rem_q <= lst.cnt;
        rd_q  <= 2'd0;
      end else if (move) begin
        rem_q <= rem_q - 3'd1;
        rd_q  <= rd_q + 2'd1;
      end

      if (move) begin
        out_valid_q <= 1'b1;
        out_last_q  <= (rem_q == 3'd1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      held_q <= held_d;
      pend_q <= res_d;
    end
    if (move) begin
      out_q <= pend_q[rd_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign token_byte_o   = out_q.ch;
  assign token_kind_o   = out_q.kind;
  assign token_start_o  = out_q.start;
  assign token_finish_o = out_q.fin;
  assign line_number_o  = out_q.line;
  assign blank_before_o = out_q.blank;
  assign run_last_o     = out_last_q;

  `CTOK_ASSERT_IMP(a_accept_drained, in_acc, rem_q <= 3'd1, "byte accepted over pending results")
  `CTOK_ASSERT_IMP(a_dots_in_sym, hc_q == 2'd2, mode_q == MODE_SYM, "two held bytes outside symbol")
  `CTOK_ASSERT_IMP(a_line_nonzero, out_valid_o, line_number_o != 16'd0, "line number is zero")
  `CTOK_ASSERT_IMP(a_end_last, out_valid_o && (token_kind_o == KIND_END), run_last_o && token_start_o && token_finish_o, "end token not a closing single beat")
  `CTOK_ASSERT_NXT(a_refill, in_acc && (lst.cnt != 3'd0), (rem_q != 3'd0) && (rd_q == 2'd0), "result buffer not loaded")

endmodule
